/* design/rhc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types, codes and constants of the record header checker.
// ----------------------------------------------------------------------------
package rhc_pkg;

  // default number of payload bytes kept for echo and sum
  localparam int unsigned KEPT_PAYLOAD_BYTES_DEF = 16;

  // width of an echo count, enough for kept-byte settings up to 127
  localparam int unsigned CNT_W = 7;

  // width of the running byte sum
  localparam int unsigned SUM_W = 12;

  // header layout
  localparam logic [8:0] HDR_VERSION_POS = 9'd4;
  localparam logic [8:0] HDR_COMMAND_POS = 9'd5;
  localparam logic [8:0] HDR_LENGTH_POS  = 9'd6;
  localparam logic [7:0] VERSION_ONE     = 8'd1;
  localparam logic [7:0] COMMAND_ECHO    = 8'd1;
  localparam logic [7:0] COMMAND_SUM     = 8'd2;

  // reject codes (magic byte faults are position plus one)
  localparam logic [2:0] REJ_NONE    = 3'd0;
  localparam logic [2:0] REJ_SHORT   = 3'd0;
  localparam logic [2:0] REJ_VERSION = 3'd5;
  localparam logic [2:0] REJ_COMMAND = 3'd6;
  localparam logic [2:0] REJ_TRUNC   = 3'd7;

  // kind of an outgoing result
  typedef enum logic [1:0] {
    KIND_ECHO   = 2'd0,
    KIND_SUM    = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_END    = 2'd3
  } result_kind_e;

  // record parsing phase
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_DONE
  } phase_e;

  // result sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT,
    BK_END
  } back_state_e;

  // one job handed from the parser to the result sequencer
  typedef struct packed {
    result_kind_e     kind;
    logic [SUM_W-1:0] sum;
    logic [2:0]       code;
    logic [CNT_W-1:0] count;
  } job_t;

  // expected magic byte at header position 0..3 ("TPAR")
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h54;
      2'd1:    val = 8'h50;
      2'd2:    val = 8'h41;
      2'd3:    val = 8'h52;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

/* design/rhc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_queue
// Two-entry job queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module rhc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  rhc_pkg::job_t      push_job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output rhc_pkg::job_t      pop_job_o,
  output logic               empty_o
);
  import rhc_pkg::*;

  job_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  // occupancy and pointers
  always_comb begin
    do_push  = push_i && (fill_q != 2'd2);
    do_pop   = pop_i && (fill_q != 2'd0);
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  assign pop_job_o = slot_q[rd_ptr_q];
  assign full_o    = (fill_q == 2'd2);
  assign empty_o   = (fill_q == 2'd0);

endmodule
`default_nettype wire

/* design/rhc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_front
// Byte parser: checks the header, counts and stores payload, queues jobs.
// ----------------------------------------------------------------------------
module rhc_front #(
  parameter  int unsigned KEPT  = rhc_pkg::KEPT_PAYLOAD_BYTES_DEF,
  localparam int unsigned IDX_W = (KEPT > 1) ? $clog2(KEPT) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // [7:0] data_byte
  input  wire logic             s_axis_tlast,   // end_of_record
  input  wire logic             queue_full_i,
  output logic                  push_o,
  output rhc_pkg::job_t         push_job_o,
  input  wire logic             echo_done_i,
  output logic                  store_we_o,
  output logic [IDX_W-1:0]      store_addr_o,
  output logic [7:0]            store_data_o
);
  import rhc_pkg::*;

  phase_e           phase_q, phase_d;
  logic [8:0]       pos_q, pos_d;
  logic [2:0]       fault_q, fault_d;
  logic             cmd_sum_q, cmd_sum_d;
  logic [7:0]       len_q, len_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             echo_busy_q, echo_busy_d;

  logic             accept;
  logic [7:0]       b;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_sat;
  logic [8:0]       idx_next;
  logic             fin;
  logic [7:0]       fin_len;
  logic [SUM_W-1:0] fin_sum;
  logic             fin_cmd_sum;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign s_axis_tready = !echo_busy_q && !queue_full_i;

  // saturating payload sum and next payload count
  always_comb begin
    sum_ext  = {1'b0, sum_q} + {{(SUM_W - 7){1'b0}}, b};
    sum_sat  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    idx_next = pos_q + 9'd1;
  end

  // parser next state
  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    fault_d      = fault_q;
    cmd_sum_d    = cmd_sum_q;
    len_d        = len_q;
    sum_d        = sum_q;
    push_o       = 1'b0;
    push_job_o   = '0;
    store_we_o   = 1'b0;
    store_addr_o = pos_q[IDX_W-1:0];
    store_data_o = b;
    fin          = 1'b0;
    fin_len      = len_q;
    fin_sum      = sum_q;
    fin_cmd_sum  = cmd_sum_q;

    if (accept) begin
      case (phase_q)
        PH_HEADER: begin
          if (pos_q < HDR_VERSION_POS) begin
            if (fault_q == REJ_NONE && b != magic_byte(pos_q[1:0])) begin
              fault_d = pos_q[2:0] + 3'd1;
            end
          end else if (pos_q == HDR_VERSION_POS) begin
            if (fault_q == REJ_NONE && b != VERSION_ONE) begin
              fault_d = REJ_VERSION;
            end
          end else if (pos_q == HDR_COMMAND_POS) begin
            if (fault_q == REJ_NONE && b != COMMAND_ECHO && b != COMMAND_SUM) begin
              fault_d = REJ_COMMAND;
            end
            cmd_sum_d = (b == COMMAND_SUM);
          end

          if (pos_q < HDR_LENGTH_POS) begin
            if (s_axis_tlast) begin
              push_o          = 1'b1;
              push_job_o.kind = KIND_REJECT;
              push_job_o.code = REJ_SHORT;
            end else begin
              pos_d = idx_next;
            end
          end else begin
            len_d = b;
            sum_d = '0;
            pos_d = '0;
            if (fault_q != REJ_NONE) begin
              push_o          = 1'b1;
              push_job_o.kind = KIND_REJECT;
              push_job_o.code = fault_q;
              phase_d         = PH_DONE;
            end else if (b == 8'd0) begin
              fin     = 1'b1;
              fin_len = 8'd0;
              fin_sum = '0;
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_PAYLOAD;
              if (s_axis_tlast) begin
                push_o          = 1'b1;
                push_job_o.kind = KIND_REJECT;
                push_job_o.code = REJ_TRUNC;
              end
            end
          end
        end

        PH_PAYLOAD: begin
          if (pos_q < 9'(KEPT)) begin
            store_we_o = 1'b1;
            sum_d      = sum_sat;
            fin_sum    = sum_sat;
          end
          pos_d = idx_next;
          if (idx_next >= {1'b0, len_q}) begin
            fin     = 1'b1;
            phase_d = PH_DONE;
          end else if (s_axis_tlast) begin
            push_o          = 1'b1;
            push_job_o.kind = KIND_REJECT;
            push_job_o.code = REJ_TRUNC;
          end
        end

        default: begin
          // trailing bytes after the results: ignored
        end
      endcase

      // completed payload: echo run or checksum
      if (fin) begin
        push_o = 1'b1;
        if (fin_cmd_sum) begin
          push_job_o.kind = KIND_SUM;
          push_job_o.sum  = fin_sum;
        end else begin
          push_job_o.kind  = KIND_ECHO;
          push_job_o.count = ({1'b0, fin_len} > 9'(KEPT)) ? CNT_W'(KEPT)
                                                          : CNT_W'(fin_len);
        end
      end

      // end of record returns the parser to the header phase
      if (s_axis_tlast) begin
        phase_d   = PH_HEADER;
        pos_d     = '0;
        fault_d   = REJ_NONE;
        cmd_sum_d = 1'b0;
        len_d     = '0;
        sum_d     = '0;
      end
    end
  end

  // echo run in flight: the store must not change under the sequencer
  always_comb begin
    echo_busy_d = echo_busy_q;
    if (echo_done_i) begin
      echo_busy_d = 1'b0;
    end
    if (push_o && push_job_o.kind == KIND_ECHO) begin
      echo_busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      fault_q     <= REJ_NONE;
      cmd_sum_q   <= 1'b0;
      len_q       <= '0;
      sum_q       <= '0;
      echo_busy_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      fault_q     <= fault_d;
      cmd_sum_q   <= cmd_sum_d;
      len_q       <= len_d;
      sum_q       <= sum_d;
      echo_busy_q <= echo_busy_d;
    end
  end

endmodule
`default_nettype wire

/* design/rhc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_back
// Result sequencer: owns the payload store and drives the output beats.
// ----------------------------------------------------------------------------
module rhc_back #(
  parameter  int unsigned KEPT  = rhc_pkg::KEPT_PAYLOAD_BYTES_DEF,
  localparam int unsigned IDX_W = (KEPT > 1) ? $clog2(KEPT) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             queue_empty_i,
  input  rhc_pkg::job_t         queue_job_i,
  output logic                  pop_o,
  input  wire logic             store_we_i,
  input  wire logic [IDX_W-1:0] store_addr_i,
  input  wire logic [7:0]       store_data_i,
  output logic                  echo_done_o,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [23:0]           m_axis_tdata,  // [7:0] echo_byte, [19:8] byte_sum,
                                               // [22:20] reject_code, [23] zero
  output logic [1:0]            m_axis_tuser,  // [1:0] result_kind
  output logic                  m_axis_tlast   // run_last
);
  import rhc_pkg::*;

  logic [7:0]       store_mem [KEPT];
  logic [7:0]       rdata_q;

  back_state_e      state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             out_valid_q, out_valid_d;
  result_kind_e     out_kind_q, out_kind_d;
  logic [7:0]       out_echo_q, out_echo_d;
  logic [SUM_W-1:0] out_sum_q, out_sum_d;
  logic [2:0]       out_code_q, out_code_d;
  logic             out_last_q, out_last_d;

  logic             can_load;
  logic             load;

  // payload store, registered read at the current echo index
  always_ff @(posedge clk_i) begin
    if (store_we_i) begin
      store_mem[store_addr_i] <= store_data_i;
    end
    rdata_q <= store_mem[idx_q];
  end

  assign can_load = !out_valid_q || m_axis_tready;

  // sequencer next state and output register loads
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    pop_o       = 1'b0;
    echo_done_o = 1'b0;
    load        = 1'b0;
    out_kind_d  = out_kind_q;
    out_echo_d  = out_echo_q;
    out_sum_d   = out_sum_q;
    out_code_d  = out_code_q;
    out_last_d  = out_last_q;

    case (state_q)
      BK_IDLE: begin
        if (!queue_empty_i) begin
          if (queue_job_i.kind == KIND_ECHO) begin
            pop_o = 1'b1;
            idx_d = '0;
            cnt_d = queue_job_i.count;
            if (queue_job_i.count == '0) begin
              state_d = BK_END;
            end else begin
              state_d = BK_READ;
            end
          end else if (can_load) begin
            pop_o      = 1'b1;
            load       = 1'b1;
            out_kind_d = queue_job_i.kind;
            out_echo_d = '0;
            out_sum_d  = (queue_job_i.kind == KIND_SUM) ? queue_job_i.sum : '0;
            out_code_d = (queue_job_i.kind == KIND_REJECT) ? queue_job_i.code : '0;
            out_last_d = 1'b1;
          end
        end
      end

      BK_READ: begin
        state_d = BK_EMIT;
      end

      BK_EMIT: begin
        if (can_load) begin
          load       = 1'b1;
          out_kind_d = KIND_ECHO;
          out_echo_d = rdata_q;
          out_sum_d  = '0;
          out_code_d = '0;
          out_last_d = 1'b0;
          if (CNT_W'(idx_q) + CNT_W'(1) == cnt_q) begin
            state_d = BK_END;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = BK_READ;
          end
        end
      end

      BK_END: begin
        if (can_load) begin
          load        = 1'b1;
          out_kind_d  = KIND_END;
          out_echo_d  = '0;
          out_sum_d   = '0;
          out_code_d  = '0;
          out_last_d  = 1'b1;
          echo_done_o = 1'b1;
          state_d     = BK_IDLE;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase

    out_valid_d = load ? 1'b1 : (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q <= out_kind_d;
      out_echo_q <= out_echo_d;
      out_sum_q  <= out_sum_d;
      out_code_q <= out_code_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_code_q, out_sum_q, out_echo_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

/* design/record_header_checker_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// record_header_checker_top
// Checks a seven-byte record header and echoes or sums the payload.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one record byte per beat, tlast on the final byte.
//   m_axis carries results: tuser is the kind, tlast marks the final result
//   caused by one input byte.
//   Input bytes are taken one per cycle while s_axis_tready is high. A
//   checksum or reject passes the job queue, then the output register,
//   before it shows on m_axis; an echo run passes the READ state (the
//   registered store read) and the EMIT state before its first beat is
//   loaded, and an empty echo run goes straight to the END state, which
//   loads its end marker. Per stored byte the sequencer reads the payload
//   store, then loads the output register. s_axis_tready stays low from
//   the beat that starts an echo run until its end marker is loaded, so
//   the store cannot change under it.
//   When m_axis stalls, the parser keeps taking bytes until the job queue
//   holds two pending jobs, then s_axis_tready stays low until a job leaves.
//   Reset clears the parser, the queue and the output valid; the payload
//   store is not cleared, only entries written in the current record are read.
// ----------------------------------------------------------------------------
module record_header_checker_top #(
  parameter int unsigned KEPT_PAYLOAD_BYTES = rhc_pkg::KEPT_PAYLOAD_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // end_of_record
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] echo_byte, [19:8] byte_sum,
                                           // [22:20] reject_code, [23] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
  output logic             m_axis_tlast    // run_last
);
  import rhc_pkg::*;

  localparam int unsigned IDX_W = (KEPT_PAYLOAD_BYTES > 1) ? $clog2(KEPT_PAYLOAD_BYTES) : 1;

  logic             push;
  job_t             push_job;
  logic             queue_full;
  logic             pop;
  job_t             pop_job;
  logic             queue_empty;
  logic             echo_done;
  logic             store_we;
  logic [IDX_W-1:0] store_addr;
  logic [7:0]       store_data;

  // byte parser
  rhc_front #(
    .KEPT (KEPT_PAYLOAD_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .push_job_o    (push_job),
    .echo_done_i   (echo_done),
    .store_we_o    (store_we),
    .store_addr_o  (store_addr),
    .store_data_o  (store_data)
  );

  // job queue
  rhc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (queue_full),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .empty_o    (queue_empty)
  );

  // result sequencer
  rhc_back #(
    .KEPT (KEPT_PAYLOAD_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (queue_empty),
    .queue_job_i   (pop_job),
    .pop_o         (pop),
    .store_we_i    (store_we),
    .store_addr_i  (store_addr),
    .store_data_i  (store_data),
    .echo_done_o   (echo_done),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire
